// ===== design/sph_pkg.sv =====
// Package for the slotted page heap manager: payload structs, action and status codes,
// and the item sizing function. No dependencies.
`default_nettype none

package sph_pkg;

  localparam logic [2:0] ACT_ALLOC  = 3'd0;
  localparam logic [2:0] ACT_DELETE = 3'd1;
  localparam logic [2:0] ACT_LOOKUP = 3'd2;
  localparam logic [2:0] ACT_WRITE  = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;
  localparam logic [1:0] ST_FREED   = 2'd3;

  // Wide enough for a sign-extended 16-bit page word plus a carry.
  typedef logic signed [17:0] sw_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [10:0] slot;
    logic [10:0] last_slot;
    logic [11:0] byte_len;
    logic [11:0] byte_offset;
    logic [7:0]  data_byte;
  } sph_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] slot_out;
    logic [10:0] word_addr;
    logic [12:0] item_bytes;
    logic        fits;
    logic [7:0]  data_out;
    logic [11:0] count_now;
    logic [11:0] free_now;
  } sph_out_t;

  // Header word plus data words for a request; at least one data word.
  function automatic logic [11:0] words_for(input logic [11:0] blen);
    logic [12:0] half;
    half = (({1'b0, blen} + 13'd1) >> 1) + 13'd1;
    return (half < 13'd2) ? 12'd2 : half[11:0];
  endfunction

  function automatic sw_t zx12(input logic [11:0] v);
    return $signed({6'd0, v});
  endfunction

endpackage

`default_nettype wire

// ===== design/sph_ifs.sv =====
// Valid/ready channel interfaces for the page heap manager's request and result sides.
// Depends on sph_pkg for the payload structs.
`default_nettype none

interface sph_in_if import sph_pkg::*; ();
  logic    valid;
  logic    ready;
  sph_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sph_out_if import sph_pkg::*; ();
  logic     valid;
  logic     ready;
  sph_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/sph_mem.sv =====
// Page memory: one write port and one read port with registered read data.
// No package dependency.
`default_nettype none

module sph_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [15:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/slotted_page_heap_manager_core.sv =====
// Slotted page heap manager: a sequencer that walks the page memory one word at a time.
// Depends on sph_pkg, sph_ifs (channel interfaces) and sph_mem.
//
// One request is handled at a time; the input is ready only between requests. Every step
// goes through the single page memory port pair, one read and one write per cycle, so the
// cost is counted in memory accesses: lookup reads the slot pointer and the item header, a
// byte access also reads and, for a write, rewrites one data word; delete grows with each
// freed slot and each slot moved down; an allocate that fits grows with each slot moved up
// and each item header passed while searching for a free fragment. A compacting allocate
// adds, per live item moved, a slot search for its pointer and a copy of its data words.
// A result can wait on the output while the block is already accepting the next request.
`default_nettype none

module slotted_page_heap_manager_core
  import sph_pkg::*;
#(
  parameter int PAGE_DEPTH = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [11:0] cfg_data,
  sph_in_if.sink           in_ch,
  sph_out_if.source        out_ch
);

  localparam int AW = $clog2(PAGE_DEPTH);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DISP    = 5'd1;
  localparam logic [4:0] S_SC_RD   = 5'd2;
  localparam logic [4:0] S_SC_CHK  = 5'd3;
  localparam logic [4:0] S_CP_RD   = 5'd4;
  localparam logic [4:0] S_CP_CHK  = 5'd5;
  localparam logic [4:0] S_SL_RD   = 5'd6;
  localparam logic [4:0] S_SL_CHK  = 5'd7;
  localparam logic [4:0] S_HDR_WR  = 5'd8;
  localparam logic [4:0] S_CPY_RD  = 5'd9;
  localparam logic [4:0] S_CPY_WR  = 5'd10;
  localparam logic [4:0] S_CP_END  = 5'd11;
  localparam logic [4:0] S_AWR     = 5'd12;
  localparam logic [4:0] S_SH_RD   = 5'd13;
  localparam logic [4:0] S_SH_WR   = 5'd14;
  localparam logic [4:0] S_SLOT_WR = 5'd15;
  localparam logic [4:0] S_D_RD    = 5'd16;
  localparam logic [4:0] S_D_HRD   = 5'd17;
  localparam logic [4:0] S_D_HCHK  = 5'd18;
  localparam logic [4:0] S_T_RD    = 5'd19;
  localparam logic [4:0] S_T_WR    = 5'd20;
  localparam logic [4:0] S_F_HRD   = 5'd21;
  localparam logic [4:0] S_F_CHK   = 5'd22;
  localparam logic [4:0] S_B_RD    = 5'd23;
  localparam logic [4:0] S_B_OP    = 5'd24;
  localparam logic [4:0] S_FIN     = 5'd25;

  localparam logic [11:0] PW_RESET = (PAGE_DEPTH < 2048) ? 12'(PAGE_DEPTH) : 12'd2048;

  logic [4:0]  state_r, state_nxt;
  logic [11:0] pw_r, pw_nxt;
  logic [11:0] cnt_r, cnt_nxt;
  logic [11:0] free_r, free_nxt;
  logic [11:0] lw_r, lw_nxt;
  sph_in_t     req_r, req_nxt;
  sw_t         ptr_r, ptr_nxt;
  sw_t         hole_r, hole_nxt;
  sw_t         w_r, w_nxt;
  sw_t         k_r, k_nxt;
  sw_t         at_r, at_nxt;
  logic [11:0] i_r, i_nxt;
  logic [11:0] dst_r, dst_nxt;
  logic [1:0]  rst_stat_r, rst_stat_nxt;
  logic [10:0] rslot_r, rslot_nxt;
  logic [10:0] rwaddr_r, rwaddr_nxt;
  logic [12:0] rbytes_r, rbytes_nxt;
  logic [7:0]  rdata_r, rdata_nxt;
  sph_out_t    out_r, out_nxt;
  logic        ovalid_r, ovalid_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata;

  logic [11:0] need;
  sw_t         gap;
  sw_t         rds;
  logic        fits_now;
  logic [11:0] cfg_sat;

  sph_mem #(.DEPTH(PAGE_DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign need     = words_for(req_r.byte_len);
  assign gap      = zx12(lw_r) - zx12(cnt_r);
  assign rds      = $signed({{2{mem_rdata[15]}}, mem_rdata});
  assign fits_now = (zx12(need) + 18'sd1) <= zx12(free_r);

  assign in_ch.ready    = (state_r == S_IDLE);
  assign out_ch.valid   = ovalid_r;
  assign out_ch.payload = out_r;

  always_comb begin
    if (cfg_data < 12'd16) begin
      cfg_sat = 12'd16;
    end else if (32'(cfg_data) > PAGE_DEPTH) begin
      cfg_sat = 12'(PAGE_DEPTH);
    end else begin
      cfg_sat = cfg_data;
    end
  end

  always_comb begin
    sw_t rest_v;
    sw_t base_v;
    state_nxt    = state_r;
    pw_nxt       = pw_r;
    cnt_nxt      = cnt_r;
    free_nxt     = free_r;
    lw_nxt       = lw_r;
    req_nxt      = req_r;
    ptr_nxt      = ptr_r;
    hole_nxt     = hole_r;
    w_nxt        = w_r;
    k_nxt        = k_r;
    at_nxt       = at_r;
    i_nxt        = i_r;
    dst_nxt      = dst_r;
    rst_stat_nxt = rst_stat_r;
    rslot_nxt    = rslot_r;
    rwaddr_nxt   = rwaddr_r;
    rbytes_nxt   = rbytes_r;
    rdata_nxt    = rdata_r;
    out_nxt      = out_r;
    ovalid_nxt   = ovalid_r;
    mem_we       = 1'b0;
    mem_waddr    = AW'(ptr_r);
    mem_wdata    = mem_rdata;
    mem_raddr    = AW'(ptr_r);
    rest_v       = rds + zx12(need);
    base_v       = ptr_r - rds;

    if (ovalid_r && out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          req_nxt      = in_ch.payload;
          rst_stat_nxt = ST_OK;
          rslot_nxt    = '0;
          rwaddr_nxt   = '0;
          rbytes_nxt   = '0;
          rdata_nxt    = '0;
          state_nxt    = S_DISP;
        end
      end
      S_DISP: begin
        mem_raddr = AW'(req_r.slot);
        case (req_r.action)
          ACT_ALLOC: begin
            if ({1'b0, req_r.slot} > cnt_r) begin
              rst_stat_nxt = ST_BAD;
              state_nxt    = S_FIN;
            end else if (!fits_now) begin
              rst_stat_nxt = ST_NOSPACE;
              state_nxt    = S_FIN;
            end else if (zx12(need) + 18'sd1 <= gap) begin
              at_nxt    = zx12(lw_r) - 18'sd1;
              lw_nxt    = lw_r - need;
              state_nxt = S_AWR;
            end else begin
              ptr_nxt   = zx12(pw_r) - 18'sd1;
              state_nxt = S_SC_RD;
            end
          end
          ACT_DELETE: begin
            if ({1'b0, req_r.last_slot} >= cnt_r || req_r.slot > req_r.last_slot) begin
              rst_stat_nxt = ST_BAD;
              state_nxt    = S_FIN;
            end else begin
              i_nxt     = {1'b0, req_r.slot};
              state_nxt = S_D_RD;
            end
          end
          ACT_LOOKUP, ACT_WRITE, ACT_READ: begin
            if ({1'b0, req_r.slot} >= cnt_r) begin
              rst_stat_nxt = ST_BAD;
              state_nxt    = S_FIN;
            end else begin
              state_nxt = S_F_HRD;
            end
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      // Walk item headers from the top of the page looking for the first free fragment.
      S_SC_RD: begin
        if (ptr_r < zx12(lw_r)) begin
          rst_stat_nxt = ST_NOSPACE;
          state_nxt    = S_FIN;
        end else begin
          state_nxt = S_SC_CHK;
        end
      end
      S_SC_CHK: begin
        if (rds <= 18'sd0) begin
          if (zx12(need) <= 18'sd1 - rds && gap > 18'sd0) begin
            at_nxt = ptr_r;
            if (rest_v <= 18'sd0) begin
              mem_we    = 1'b1;
              mem_waddr = AW'(ptr_r - zx12(need));
              mem_wdata = rest_v[15:0];
            end
            state_nxt = S_AWR;
          end else begin
            hole_nxt  = ptr_r;
            ptr_nxt   = ptr_r - 18'sd1 + rds;
            state_nxt = S_CP_RD;
          end
        end else begin
          ptr_nxt   = ptr_r - rds - 18'sd1;
          state_nxt = S_SC_RD;
        end
      end
      // Compaction: ptr is the probe, hole_r the header slot that the next live item fills.
      S_CP_RD: begin
        if (ptr_r < zx12(lw_r)) begin
          lw_nxt    = hole_r[11:0] + 12'd1;
          state_nxt = S_CP_END;
        end else begin
          state_nxt = S_CP_CHK;
        end
      end
      S_CP_CHK: begin
        if (rds <= 18'sd0) begin
          ptr_nxt   = ptr_r - 18'sd1 + rds;
          state_nxt = S_CP_RD;
        end else begin
          w_nxt     = rds;
          i_nxt     = '0;
          state_nxt = S_SL_RD;
        end
      end
      S_SL_RD: begin
        mem_raddr = AW'(i_r);
        if (i_r >= cnt_r) begin
          state_nxt = S_HDR_WR;
        end else begin
          state_nxt = S_SL_CHK;
        end
      end
      S_SL_CHK: begin
        if ($signed({2'b00, mem_rdata}) == ptr_r) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(i_r);
          mem_wdata = hole_r[15:0];
          state_nxt = S_HDR_WR;
        end else begin
          i_nxt     = i_r + 12'd1;
          state_nxt = S_SL_RD;
        end
      end
      S_HDR_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(hole_r);
        mem_wdata = w_r[15:0];
        k_nxt     = w_r - 18'sd1;
        state_nxt = S_CPY_RD;
      end
      S_CPY_RD: begin
        mem_raddr = AW'(ptr_r - w_r + k_r);
        if (k_r < 18'sd0) begin
          hole_nxt  = hole_r - w_r - 18'sd1;
          ptr_nxt   = ptr_r - w_r - 18'sd1;
          state_nxt = S_CP_RD;
        end else begin
          state_nxt = S_CPY_WR;
        end
      end
      S_CPY_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(hole_r - w_r + k_r);
        mem_wdata = mem_rdata;
        k_nxt     = k_r - 18'sd1;
        state_nxt = S_CPY_RD;
      end
      S_CP_END: begin
        if (zx12(need) + 18'sd1 > gap) begin
          rst_stat_nxt = ST_NOSPACE;
          state_nxt    = S_FIN;
        end else begin
          at_nxt    = zx12(lw_r) - 18'sd1;
          lw_nxt    = lw_r - need;
          state_nxt = S_AWR;
        end
      end
      S_AWR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(at_r);
        mem_wdata = 16'(need - 12'd1);
        i_nxt     = cnt_r;
        state_nxt = S_SH_RD;
      end
      // Open the slot position by moving the pointers at and above it up by one.
      S_SH_RD: begin
        mem_raddr = AW'(i_r - 12'd1);
        if (i_r <= {1'b0, req_r.slot}) begin
          state_nxt = S_SLOT_WR;
        end else begin
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(i_r);
        mem_wdata = mem_rdata;
        i_nxt     = i_r - 12'd1;
        state_nxt = S_SH_RD;
      end
      S_SLOT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(req_r.slot);
        mem_wdata = at_r[15:0];
        cnt_nxt   = cnt_r + 12'd1;
        free_nxt  = free_r - need - 12'd1;
        rslot_nxt = req_r.slot;
        state_nxt = S_FIN;
      end
      S_D_RD: begin
        mem_raddr = AW'(i_r);
        if (i_r > {1'b0, req_r.last_slot}) begin
          i_nxt     = {1'b0, req_r.last_slot} + 12'd1;
          dst_nxt   = {1'b0, req_r.slot};
          state_nxt = S_T_RD;
        end else begin
          state_nxt = S_D_HRD;
        end
      end
      S_D_HRD: begin
        mem_raddr = AW'(mem_rdata);
        ptr_nxt   = $signed({2'b00, mem_rdata});
        state_nxt = S_D_HCHK;
      end
      S_D_HCHK: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(ptr_r);
        mem_wdata = 16'(-rds);
        free_nxt  = free_r + 12'(rds + 18'sd2);
        i_nxt     = i_r + 12'd1;
        state_nxt = S_D_RD;
      end
      // Close the gap: move the pointers above the deleted range down.
      S_T_RD: begin
        mem_raddr = AW'(i_r);
        if (i_r >= cnt_r) begin
          cnt_nxt   = cnt_r - ({1'b0, req_r.last_slot} - {1'b0, req_r.slot} + 12'd1);
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_T_WR;
        end
      end
      S_T_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(dst_r);
        mem_wdata = mem_rdata;
        i_nxt     = i_r + 12'd1;
        dst_nxt   = dst_r + 12'd1;
        state_nxt = S_T_RD;
      end
      S_F_HRD: begin
        mem_raddr = AW'(mem_rdata);
        ptr_nxt   = $signed({2'b00, mem_rdata});
        state_nxt = S_F_CHK;
      end
      S_F_CHK: begin
        if (rds <= 18'sd0) begin
          rst_stat_nxt = ST_FREED;
          state_nxt    = S_FIN;
        end else begin
          rwaddr_nxt = base_v[10:0];
          rbytes_nxt = 13'(rds <<< 1);
          if (req_r.action == ACT_LOOKUP) begin
            state_nxt = S_FIN;
          end else if (zx12(req_r.byte_offset) + 18'sd1 > (rds <<< 1)) begin
            rst_stat_nxt = ST_FREED;
            state_nxt    = S_FIN;
          end else begin
            ptr_nxt   = base_v + zx12(req_r.byte_offset >> 1);
            state_nxt = S_B_RD;
          end
        end
      end
      S_B_RD: begin
        state_nxt = S_B_OP;
      end
      S_B_OP: begin
        if (req_r.action == ACT_WRITE) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(ptr_r);
          mem_wdata = req_r.byte_offset[0] ? {req_r.data_byte, mem_rdata[7:0]}
                                           : {mem_rdata[15:8], req_r.data_byte};
        end else begin
          rdata_nxt = req_r.byte_offset[0] ? mem_rdata[15:8] : mem_rdata[7:0];
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!ovalid_r || out_ch.ready) begin
          out_nxt.status     = rst_stat_r;
          out_nxt.slot_out   = rslot_r;
          out_nxt.word_addr  = rwaddr_r;
          out_nxt.item_bytes = rbytes_r;
          out_nxt.fits       = (req_r.action == ACT_LOOKUP) && fits_now;
          out_nxt.data_out   = rdata_r;
          out_nxt.count_now  = cnt_r;
          out_nxt.free_now   = free_r;
          ovalid_nxt         = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Page size writes reformat the page; the user must write only while idle, unchecked.
    if (cfg_we) begin
      pw_nxt   = cfg_sat;
      cnt_nxt  = '0;
      free_nxt = cfg_sat;
      lw_nxt   = cfg_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pw_r     <= PW_RESET;
      cnt_r    <= '0;
      free_r   <= PW_RESET;
      lw_r     <= PW_RESET;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pw_r     <= pw_nxt;
      cnt_r    <= cnt_nxt;
      free_r   <= free_nxt;
      lw_r     <= lw_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    ptr_r      <= ptr_nxt;
    hole_r     <= hole_nxt;
    w_r        <= w_nxt;
    k_r        <= k_nxt;
    at_r       <= at_nxt;
    i_r        <= i_nxt;
    dst_r      <= dst_nxt;
    rst_stat_r <= rst_stat_nxt;
    rslot_r    <= rslot_nxt;
    rwaddr_r   <= rwaddr_nxt;
    rbytes_r   <= rbytes_nxt;
    rdata_r    <= rdata_nxt;
    out_r      <= out_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_le_pw: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= pw_r)
    else $error("slot count exceeds page size");
  a_lw_ge_cnt: assert property (@(posedge clk) disable iff (!rst_n) lw_r >= cnt_r)
    else $error("item area overlaps slot array");
  a_free_le_pw: assert property (@(posedge clk) disable iff (!rst_n) free_r <= pw_r)
    else $error("free words exceed page size");
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
      $rose(ovalid_r) |-> $past(state_r) == S_FIN)
    else $error("result raised outside the finish step");
`endif

endmodule

`default_nettype wire
